FILE: rtl/bit_pkg.sv
// Package with shared types and constants for the binary image thinning block.
package bit_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_THIN  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int MIN_BG = 2;
    localparam int MAX_BG = 6;

    localparam logic [16:0] TOTAL_SAT = 17'h1FFFF;
    localparam logic [15:0] PASS_SAT  = 16'hFFFF;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] pixel_in;
    } item_t;

    typedef struct packed {
        logic [7:0]  pixel_out;
        logic [16:0] removed_total;
        logic [15:0] pass_count;
    } result_t;

    typedef struct packed {
        logic [8:0]  index;
        logic [15:0] data;
    } cfg_t;

    // Zhang-Suen removal test on a 3x3 window of foreground bits.
    // Ring order: N, NE, E, SE, S, SW, W, NW in bits 0..7.
    function automatic logic zs_remove(input logic [7:0] nb, input logic second);
        logic [3:0] bg;
        logic [3:0] trans;
        logic       ok;
        bg = 4'd0;
        trans = 4'd0;
        for (int k = 0; k < 8; k++) begin
            bg = bg + {3'd0, ~nb[k]};
            trans = trans + {3'd0, (~nb[k]) & nb[(k + 1) % 8]};
        end
        ok = (bg >= 4'(MIN_BG)) && (bg <= 4'(MAX_BG)) && (trans == 4'd1);
        if (!second)
            ok = ok && !(nb[0] & nb[2] & nb[4]) && !(nb[2] & nb[4] & nb[6]);
        else
            ok = ok && !(nb[0] & nb[2] & nb[6]) && !(nb[0] & nb[4] & nb[6]);
        return ok;
    endfunction

endpackage

FILE: rtl/bit_if.sv
// Valid/ready stream interface used by every channel of the block.
interface bit_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/bit_core.sv
// Sequencer, image memories and shared removal test of the thinning block.
module bit_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bit_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output bit_pkg::result_t out_item,
    input  logic [8:0]      act_w,
    input  logic [8:0]      act_h
);
    import bit_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int AW = CW + RW;
    localparam int DEPTH = 1 << AW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDW   = 4'd1;
    localparam logic [3:0] S_RDD   = 4'd2;
    localparam logic [3:0] S_MADDR = 4'd3;
    localparam logic [3:0] S_MWAIT = 4'd4;
    localparam logic [3:0] S_MREAD = 4'd5;
    localparam logic [3:0] S_MEVAL = 4'd6;
    localparam logic [3:0] S_CADDR = 4'd7;
    localparam logic [3:0] S_CWAIT = 4'd8;
    localparam logic [3:0] S_CDO   = 4'd9;
    localparam logic [3:0] S_PEND  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [7:0] img_mem [DEPTH];
    logic       mark_mem [DEPTH];

    logic [3:0]    state_reg, state_next;
    logic [RW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic [3:0]    k_reg, k_next;
    logic          sub_reg, sub_next;
    logic [8:0]    nb_reg, nb_next;
    logic [16:0]   pass_reg, pass_next;
    logic [16:0]   total_reg, total_next;
    logic [15:0]   passes_reg, passes_next;
    result_t       res_reg, res_next;
    item_t         it_reg, it_next;

    logic [AW-1:0] img_addr;
    logic          img_we;
    logic [7:0]    img_wd;
    logic [7:0]    img_rd;
    logic          mark_we, mark_wd, mark_rd;

    // Offsets: k=0 centre, then ring N..NW.
    logic signed [9:0] nr, nc;
    logic              nb_in;
    logic              last_col, last_row;
    logic [17:0]       sum;

    always_comb
    begin
        nr = $signed({2'b0, r_reg});
        nc = $signed({2'b0, c_reg});
        case (k_reg)
            4'd1: begin nr = nr - 10'sd1; end
            4'd2: begin nr = nr - 10'sd1; nc = nc + 10'sd1; end
            4'd3: begin nc = nc + 10'sd1; end
            4'd4: begin nr = nr + 10'sd1; nc = nc + 10'sd1; end
            4'd5: begin nr = nr + 10'sd1; end
            4'd6: begin nr = nr + 10'sd1; nc = nc - 10'sd1; end
            4'd7: begin nc = nc - 10'sd1; end
            4'd8: begin nr = nr - 10'sd1; nc = nc - 10'sd1; end
            default: ;
        endcase
    end

    logic nb_inside;
    assign nb_inside = (nr >= 0) && (nc >= 0) && (nr < $signed({1'b0, act_h}))
                       && (nc < $signed({1'b0, act_w}));
    assign last_col = ({{(9 - CW){1'b0}}, c_reg} == act_w - 9'd1);
    assign last_row = ({{(9 - RW){1'b0}}, r_reg} == act_h - 9'd1);
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_item = res_reg;

    always_comb
    begin
        img_addr = {r_reg, c_reg};
        img_we = 1'b0;
        img_wd = 8'd0;
        mark_we = 1'b0;
        mark_wd = 1'b0;
        if (state_reg == S_IDLE)
        begin
            img_addr = {in_item.row[RW-1:0], in_item.col[CW-1:0]};
            img_we = in_valid && (in_item.cmd == CMD_WRITE)
                     && ({1'b0, in_item.row} < act_h) && ({1'b0, in_item.col} < act_w);
            img_wd = in_item.pixel_in;
        end
        else if (state_reg == S_RDW || state_reg == S_RDD)
            img_addr = {it_reg.row[RW-1:0], it_reg.col[CW-1:0]};
        else if (state_reg == S_MADDR || state_reg == S_MWAIT)
            img_addr = {nr[RW-1:0], nc[CW-1:0]};
        else if (state_reg == S_MEVAL)
        begin
            mark_we = 1'b1;
            mark_wd = nb_reg[0] && zs_remove(nb_reg[8:1], sub_reg);
        end
        else if (state_reg == S_CDO)
        begin
            img_we = mark_rd;
            img_wd = 8'd0;
            mark_we = 1'b1;
            mark_wd = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (img_we)
            img_mem[img_addr] <= img_wd;
        img_rd <= img_mem[img_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[{r_reg, c_reg}] <= mark_wd;
        mark_rd <= mark_mem[{r_reg, c_reg}];
    end

    assign nb_in = (img_rd != 8'd0);
    assign sum = {1'b0, total_reg} + {1'b0, pass_reg};

    always_comb
    begin
        state_next = state_reg;
        r_next = r_reg;
        c_next = c_reg;
        k_next = k_reg;
        sub_next = sub_reg;
        nb_next = nb_reg;
        pass_next = pass_reg;
        total_next = total_reg;
        passes_next = passes_reg;
        res_next = res_reg;
        it_next = it_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    it_next = in_item;
                    if (in_item.cmd == CMD_READ)
                        state_next = S_RDW;
                    else if (in_item.cmd == CMD_THIN)
                    begin
                        r_next = '0;
                        c_next = '0;
                        k_next = 4'd0;
                        sub_next = 1'b0;
                        pass_next = '0;
                        total_next = '0;
                        passes_next = '0;
                        state_next = S_MADDR;
                    end
                end
            end
            S_RDW: state_next = S_RDD;
            S_RDD:
            begin
                res_next.pixel_out = (({1'b0, it_reg.row} < act_h)
                    && ({1'b0, it_reg.col} < act_w)) ? img_rd : 8'd0;
                res_next.removed_total = '0;
                res_next.pass_count = '0;
                state_next = S_OUT;
            end
            S_MADDR:
            begin
                if (!nb_inside)
                begin
                    nb_next[k_reg] = 1'b0;
                    state_next = (k_reg == 4'd8) ? S_MEVAL : S_MADDR;
                    k_next = k_reg + 4'd1;
                end
                else
                    state_next = S_MWAIT;
            end
            S_MWAIT: state_next = S_MREAD;
            S_MREAD:
            begin
                nb_next[k_reg] = nb_in;
                k_next = k_reg + 4'd1;
                state_next = (k_reg == 4'd8) ? S_MEVAL : S_MADDR;
            end
            S_MEVAL:
            begin
                k_next = 4'd0;
                if (last_col)
                begin
                    c_next = '0;
                    if (last_row)
                    begin
                        r_next = '0;
                        state_next = S_CADDR;
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                        state_next = S_MADDR;
                    end
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                    state_next = S_MADDR;
                end
            end
            S_CADDR: state_next = S_CWAIT;
            S_CWAIT: state_next = S_CDO;
            S_CDO:
            begin
                if (mark_rd && pass_reg != TOTAL_SAT)
                    pass_next = pass_reg + 17'd1;
                state_next = S_CADDR;
                if (last_col)
                begin
                    c_next = '0;
                    if (last_row)
                    begin
                        r_next = '0;
                        state_next = S_PEND;
                    end
                    else
                        r_next = r_reg + 1'b1;
                end
                else
                    c_next = c_reg + 1'b1;
            end
            S_PEND:
            begin
                if (!sub_reg)
                begin
                    sub_next = 1'b1;
                    state_next = S_MADDR;
                end
                else
                begin
                    sub_next = 1'b0;
                    total_next = sum[17] || sum[16:0] == TOTAL_SAT ? TOTAL_SAT : sum[16:0];
                    if (passes_reg != PASS_SAT)
                        passes_next = passes_reg + 16'd1;
                    pass_next = '0;
                    if (pass_reg == 17'd0)
                    begin
                        res_next.pixel_out = 8'd0;
                        res_next.removed_total = total_reg;
                        res_next.pass_count = (passes_reg != PASS_SAT) ?
                            passes_reg + 16'd1 : passes_reg;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_MADDR;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        c_reg <= c_next;
        k_reg <= k_next;
        sub_reg <= sub_next;
        nb_reg <= nb_next;
        pass_reg <= pass_next;
        total_reg <= total_next;
        passes_reg <= passes_next;
        res_reg <= res_next;
        it_reg <= it_next;
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("ready while a result is held");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result lost under stall");
    a_k: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MEVAL |-> k_reg == 4'd9) else $error("window incomplete");
endmodule

FILE: rtl/binary_image_thinning.sv
// Top level of the binary image thinning block.
// The block keeps an image of up to MAX_HEIGHT x MAX_WIDTH 8-bit pixels in an
// on-chip memory with one access port. A write command stores one pixel when
// it is taken. A read command passes through the states S_RDW and S_RDD and
// returns the stored pixel in one result transfer. A thin command runs
// Zhang-Suen passes until a pass removes nothing; each subpass sweeps the
// active region twice: a marking sweep that fetches the 3x3 window one pixel
// at a time through the single memory port, skipping neighbours outside the
// region, and a clearing sweep. After the last pass, one result transfer
// carries the removal total and the pass count. The removal marks are cleared
// by the clearing sweep itself, so no clearing pass is run after reset.
module binary_image_thinning #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input logic clk,
    input logic rst_n,
    bit_stream_if.sink   cfg,
    bit_stream_if.sink   in_ch,
    bit_stream_if.source out_ch
);
    import bit_pkg::*;

    logic [8:0] width_reg, height_reg;
    logic [8:0] act_w, act_h;
    cfg_t       cfg_d;
    item_t      in_d;
    result_t    out_d;

    assign cfg_d = cfg.data;
    assign in_d = in_ch.data;
    assign out_ch.data = out_d;
    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (cfg.valid)
        begin
            if (cfg_d.index == {8'd0, REG_WIDTH})
                width_reg <= cfg_d.data[8:0];
            else if (cfg_d.index == {8'd0, REG_HEIGHT})
                height_reg <= cfg_d.data[8:0];
        end
    end

    // Out-of-range sizes clamp to the legal range.
    assign act_w = (width_reg == 9'd0) ? 9'd1 :
                   (width_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_reg;
    assign act_h = (height_reg == 9'd0) ? 9'd1 :
                   (height_reg > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_reg;

    bit_core #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_core (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_d),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_d),
        .act_w(act_w), .act_h(act_h)
    );

    a_w: assert property (@(posedge clk) disable iff (!rst_n)
        act_w != 9'd0 && act_h != 9'd0) else $error("zero active size");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg_d.index == 9'd0 |=> width_reg == $past(cfg_d.data[8:0]))
        else $error("width write lost");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input taken while result held");
endmodule

FILE: tb/tb.sv
// Self-checking testbench for the binary image thinning block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bit_pkg::*;

    localparam int  IMG_DIM    = 256;
    localparam int  STORE_SIZE = IMG_DIM * IMG_DIM;
    localparam int  SETTLE     = 10;
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    bit_stream_if #(.W($bits(cfg_t)))    cfg_ch ();
    bit_stream_if #(.W($bits(item_t)))   in_ch ();
    bit_stream_if #(.W($bits(result_t))) out_ch ();

    binary_image_thinning #(
        .MAX_WIDTH (IMG_DIM),
        .MAX_HEIGHT(IMG_DIM)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    // Commands waiting to be sent, and results the shadow image predicts.
    item_t   cmd_queue[$];
    result_t expected_results[$];

    // Shadow copy of the block: image, removal marks and the two registers.
    logic [7:0] shadow_img [0:STORE_SIZE-1];
    bit         shadow_mark[0:STORE_SIZE-1];
    logic [8:0] shadow_width  = 9'd256;
    logic [8:0] shadow_height = 9'd256;

    int     mismatches = 0;
    bit     calm = 1'b0;
    int     send_gap = 0;
    int     recv_stall = 0;
    int     items_made = 0;
    longint cycles = 0;

    // A register value of zero acts as one, and one above the maximum acts
    // as the maximum.
    function automatic int eff_size(input logic [8:0] value);
        if (value == 9'd0)
            return 1;
        if (value > 9'(IMG_DIM))
            return IMG_DIM;
        return int'(value);
    endfunction

    function automatic bit is_fg(input int r, input int c, input int h, input int w);
        if (r < 0 || c < 0 || r >= h || c >= w)
            return 1'b0;
        return shadow_img[r * IMG_DIM + c] != 8'd0;
    endfunction

    // One subpass: judge every foreground pixel against the image as it
    // stood before, then clear the marked pixels. Returns the count removed.
    function automatic int thin_subpass(input bit second, input int h, input int w);
        int dr[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
        int dc[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
        bit nb[8];
        int bg;
        int steps;
        bit ok;
        int removed;
        removed = 0;
        for (int a = 0; a < STORE_SIZE; a++)
            shadow_mark[a] = 1'b0;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (shadow_img[r * IMG_DIM + c] == 8'd0)
                    continue;
                bg = 0;
                steps = 0;
                for (int k = 0; k < 8; k++) begin
                    nb[k] = is_fg(r + dr[k], c + dc[k], h, w);
                    if (!nb[k])
                        bg++;
                end
                for (int k = 0; k < 8; k++)
                    if (!nb[k] && nb[(k + 1) % 8])
                        steps++;
                ok = (bg >= MIN_BG) && (bg <= MAX_BG) && (steps == 1);
                if (!second)
                    ok = ok && !(nb[0] && nb[2] && nb[4]) && !(nb[2] && nb[4] && nb[6]);
                else
                    ok = ok && !(nb[0] && nb[2] && nb[6]) && !(nb[0] && nb[4] && nb[6]);
                if (ok)
                    shadow_mark[r * IMG_DIM + c] = 1'b1;
            end
        end
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                if (shadow_mark[r * IMG_DIM + c]) begin
                    shadow_img[r * IMG_DIM + c] = 8'd0;
                    removed++;
                end
        return removed;
    endfunction

    // Work out the result, if any, that one accepted command causes.
    function automatic void predict_command(input item_t it);
        int h;
        int w;
        int pass_removed;
        int total;
        int passes;
        result_t res;
        h = eff_size(shadow_height);
        w = eff_size(shadow_width);
        res = '0;
        case (it.cmd)
            CMD_WRITE:
            begin
                if (int'(it.row) < h && int'(it.col) < w)
                    shadow_img[int'(it.row) * IMG_DIM + int'(it.col)] = it.pixel_in;
            end
            CMD_READ:
            begin
                if (int'(it.row) < h && int'(it.col) < w)
                    res.pixel_out = shadow_img[int'(it.row) * IMG_DIM + int'(it.col)];
                expected_results.push_back(res);
            end
            CMD_THIN:
            begin
                total = 0;
                passes = 0;
                do
                begin
                    pass_removed = thin_subpass(1'b0, h, w) + thin_subpass(1'b1, h, w);
                    if (pass_removed > int'(TOTAL_SAT))
                        pass_removed = int'(TOTAL_SAT);
                    total += pass_removed;
                    if (total > int'(TOTAL_SAT))
                        total = int'(TOTAL_SAT);
                    if (passes < int'(PASS_SAT))
                        passes++;
                end
                while (pass_removed != 0);
                res.removed_total = 17'(total);
                res.pass_count = 16'(passes);
                expected_results.push_back(res);
            end
            default:
            begin
                // The unused command value is dropped without a result.
            end
        endcase
    endfunction

    // Command driver: presents the next queued command, with random gaps,
    // and feeds the shadow image with every command the block takes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_command(item_t'(in_ch.data));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    send_gap <= $urandom_range(0, 17);
                    in_ch.valid <= 1'b0;
                end
                else if (cmd_queue.size() > 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= cmd_queue.pop_front();
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: stalls at random and compares every result transfer
    // with the oldest prediction, field by field.
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = result_t'(out_ch.data);
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: pixel %0d removed %0d passes %0d",
                                 got.pixel_out, got.removed_total, got.pass_count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.pixel_out !== want.pixel_out
                        || got.removed_total !== want.removed_total
                        || got.pass_count !== want.pass_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: pixel %0d/%0d removed %0d/%0d passes %0d/%0d",
                                     want.pixel_out, got.pixel_out,
                                     want.removed_total, got.removed_total,
                                     want.pass_count, got.pass_count);
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                recv_stall <= $urandom_range(0, 17);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** binary_image_thinning: FAILED **");
            $finish;
        end
    end

    function automatic void add_cmd(input logic [1:0] cmd, input int r, input int c,
                                    input int pix);
        item_t it;
        it.cmd = cmd;
        it.row = 8'(r);
        it.col = 8'(c);
        it.pixel_in = 8'(pix);
        cmd_queue.push_back(it);
        items_made++;
    endfunction

    // Write one register while the block is idle.
    task automatic write_reg(input logic reg_sel, input int value);
        cfg_t word;
        word.index = 9'(reg_sel);
        word.data = 16'(value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= word;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (reg_sel == REG_WIDTH)
            shadow_width = 9'(value);
        else
            shadow_height = 9'(value);
    endtask

    // Let every queued command go in and every predicted result come out.
    task automatic wait_idle();
        while (cmd_queue.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One phase: set the region, fill it with a random shape, then a random
    // mix of writes, reads, thins and noise, closed by one thin and reads.
    task automatic run_phase(input int wreg, input int hreg, input int nrand);
        int w;
        int h;
        int r0;
        int r1;
        int c0;
        int c1;
        int pick;
        int pix;
        write_reg(REG_WIDTH, wreg);
        write_reg(REG_HEIGHT, hreg);
        w = eff_size(9'(wreg));
        h = eff_size(9'(hreg));
        r0 = $urandom_range(0, h - 1);
        r1 = $urandom_range(r0, h - 1);
        c0 = $urandom_range(0, w - 1);
        c1 = $urandom_range(c0, w - 1);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
            begin
                if ((r >= r0 && r <= r1 && c >= c0 && c <= c1) || $urandom_range(0, 9) == 0)
                    pix = $urandom_range(1, 255);
                else
                    pix = 0;
                add_cmd(CMD_WRITE, r, c, pix);
            end
        for (int n = 0; n < nrand; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                add_cmd(CMD_WRITE, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
                        $urandom_range(0, 1) ? $urandom_range(0, 255) : 0);
            else if (pick < 50 && w < IMG_DIM)
                add_cmd($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, $urandom_range(0, 255),
                        $urandom_range(w, 255), $urandom_range(0, 255));
            else if (pick < 55 && h < IMG_DIM)
                add_cmd($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, $urandom_range(h, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255));
            else if (pick < 88)
                add_cmd(CMD_READ, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
                        $urandom_range(0, 255));
            else if (pick < 92)
                add_cmd(CMD_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
            else if (w * h <= 100)
                add_cmd(CMD_THIN, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
        end
        add_cmd(CMD_THIN, 0, 0, 0);
        for (int n = 0; n < 4; n++)
            add_cmd(CMD_READ, $urandom_range(0, h - 1), $urandom_range(0, w - 1), 0);
        wait_idle();
    endtask

    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset size of 256 x 256: corners, extreme
        // pixel values, the unused command and reads of written corners.
        add_cmd(CMD_WRITE, 0, 0, 255);
        add_cmd(CMD_WRITE, 255, 255, 1);
        add_cmd(CMD_WRITE, 0, 255, 128);
        add_cmd(CMD_WRITE, 255, 0, 0);
        add_cmd(CMD_READ, 0, 0, 255);
        add_cmd(CMD_READ, 255, 255, 0);
        add_cmd(CMD_READ, 0, 255, 0);
        add_cmd(CMD_READ, 255, 0, 0);
        add_cmd(CMD_UNUSED, 255, 255, 255);
        add_cmd(CMD_WRITE, 127, 128, 170);
        add_cmd(CMD_READ, 127, 128, 85);
        wait_idle();

        // A single pixel, a 3 x 3 block, a width of zero with a height above
        // the maximum, a full-width strip of one row and a 16 x 16 region.
        run_phase(1, 1, 6);
        run_phase(3, 3, 10);
        run_phase(0, 511, 30);
        run_phase(256, 1, 30);
        run_phase(16, 16, 20);

        // Random small regions until the item budget is spent; the last
        // phase runs with no gaps and no stalls.
        while (items_made < 1650)
            run_phase($urandom_range(0, 10), $urandom_range(0, 10), 40);
        calm = 1'b1;
        run_phase(8, 8, 40);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("** binary_image_thinning: PASSED **");
        else
            $display("** binary_image_thinning: FAILED **");
        $finish;
    end

endmodule
